/* src/msq_pkg.sv */
`default_nettype none
package msq_pkg;

   localparam int VideoSlotsDefault = 16;
   localparam int AudioSlotsDefault = 16;
   localparam int CsrIndexWidth     = 1;
   localparam int CsrDataWidth      = 16;
   localparam int QueueDepth        = 2;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_PULL  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] KIND_VIDEO = 2'd0;
   localparam logic [1:0] KIND_KEY   = 2'd1;
   localparam logic [1:0] KIND_AUDIO = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_TOOLONG = 3'd1;
   localparam logic [2:0] ST_NOSLOT  = 3'd2;
   localparam logic [2:0] ST_DROP    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CSR_VIDEO_BYTES = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_AUDIO_BYTES = 1'd1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  media_kind;
      logic [15:0] length;
      logic [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [1:0]  out_kind;
      logic [15:0] out_length;
      logic [31:0] out_timestamp;
      logic [31:0] out_seq;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      cmd_type     cmd;
      logic        is_audio;
      logic        key;
      logic        too_long;
      logic [15:0] length;
      logic [31:0] timestamp;
      logic [31:0] seq;
   } work_type;

endpackage
`default_nettype wire

/* src/msq_ram.sv */
`default_nettype none
module msq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/msq_front.sv */
`default_nettype none
module msq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire msq_pkg::req_type req,
   input  wire logic             csr_we,
   input  wire logic [msq_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [msq_pkg::CsrDataWidth-1:0]  csr_wdata,
   output msq_pkg::work_type     work
);
   logic [15:0] video_bytes_ff;
   logic [15:0] audio_bytes_ff;
   logic [31:0] counter_ff;
   logic        is_push;
   logic        is_video_push;
   logic        audio_kind;

   assign audio_kind    = req.media_kind[1];
   assign is_push       = (req.cmd == msq_pkg::CMD_PUSH);
   assign is_video_push = is_push && !audio_kind;

   // hold limits and advance the sequence counter on every accepted video push
   always_ff @(posedge clock) begin
      if (reset) begin
         video_bytes_ff <= 16'hFFFF;
         audio_bytes_ff <= 16'd4096;
         counter_ff     <= '0;
      end else begin
         if (csr_we && csr_index == msq_pkg::CSR_VIDEO_BYTES) video_bytes_ff <= csr_wdata;
         if (csr_we && csr_index == msq_pkg::CSR_AUDIO_BYTES) audio_bytes_ff <= csr_wdata;
         if (accept && is_video_push) counter_ff <= counter_ff + 32'd1;
      end
   end

   // classify the transaction
   always_comb begin
      work.cmd       = msq_pkg::cmd_type'(req.cmd);
      work.is_audio  = (req.cmd == msq_pkg::CMD_PULL) ? (req.media_kind == msq_pkg::KIND_AUDIO)
                                                      : audio_kind;
      work.key       = (req.media_kind == msq_pkg::KIND_KEY);
      work.too_long  = audio_kind ? (req.length > audio_bytes_ff)
                                  : (req.length > video_bytes_ff);
      work.length    = req.length;
      work.timestamp = req.timestamp;
      work.seq       = counter_ff + 32'd1;
   end
endmodule
`default_nettype wire

/* src/msq_queue.sv */
`default_nettype none
module msq_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire msq_pkg::work_type push_data,
   input  wire logic              pop,
   output msq_pkg::work_type      head,
   output logic                   empty,
   output logic                   full
);
   localparam int Aw = $clog2(msq_pkg::QueueDepth);
   msq_pkg::work_type    entry_ff [msq_pkg::QueueDepth];
   logic [Aw-1:0]        wr_ff;
   logic [Aw-1:0]        rd_ff;
   logic [Aw:0]          count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (Aw+1)'(msq_pkg::QueueDepth));
   assign head  = entry_ff[rd_ff];

   // advance pointers on push and pop
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (Aw+1)'(push) - (Aw+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

/* src/msq_back.sv */
`default_nettype none
module msq_back #(
   parameter int VideoSlots = msq_pkg::VideoSlotsDefault,
   parameter int AudioSlots = msq_pkg::AudioSlotsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              work_valid,
   input  wire msq_pkg::work_type work,
   output logic                   work_pop,
   output logic                   rsp_valid,
   output msq_pkg::rsp_type       rsp_data
);
   localparam int Vw = (VideoSlots > 1) ? $clog2(VideoSlots) : 1;
   localparam int Aw = (AudioSlots > 1) ? $clog2(AudioSlots) : 1;
   localparam int VdW = 32 + 16 + 32 + 1;
   localparam int AdW = 32 + 16;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DRAIN_V, S_DRAIN_A} state_type;

   state_type       state_ff;
   msq_pkg::work_type cur_ff;
   logic [Vw:0]     vfree_cnt_ff, vfifo_cnt_ff;
   logic [Vw-1:0]   vhead_ff;
   logic [Aw:0]     afree_cnt_ff, afifo_cnt_ff;
   logic [Aw-1:0]   ahead_ff;
   logic [Vw-1:0]   vstack_ff [VideoSlots];
   logic [Vw-1:0]   vfifo_ff  [VideoSlots];
   logic [Aw-1:0]   astack_ff [AudioSlots];
   logic [Aw-1:0]   afifo_ff  [AudioSlots];
   msq_pkg::rsp_type rsp_in;

   logic            vd_we, ad_we;
   logic [Vw-1:0]   vd_waddr, vd_raddr;
   logic [Aw-1:0]   ad_waddr, ad_raddr;
   logic [VdW-1:0]  vd_wdata, vd_rdata;
   logic [AdW-1:0]  ad_wdata, ad_rdata;

   logic [Vw-1:0]   vtail_slot, vhead_slot, vtop_slot;
   logic [Aw-1:0]   ahead_slot, atop_slot;

   function automatic logic [Vw-1:0] vwrap(input logic [Vw:0] x);
      return (x >= (Vw+1)'(VideoSlots)) ? Vw'(x - (Vw+1)'(VideoSlots)) : Vw'(x);
   endfunction
   function automatic logic [Aw-1:0] awrap(input logic [Aw:0] x);
      return (x >= (Aw+1)'(AudioSlots)) ? Aw'(x - (Aw+1)'(AudioSlots)) : Aw'(x);
   endfunction

   assign vtail_slot = vfifo_ff[vwrap((Vw+1)'(vhead_ff) + vfifo_cnt_ff - 1'b1)];
   assign vhead_slot = vfifo_ff[vhead_ff];
   assign ahead_slot = afifo_ff[ahead_ff];
   assign vtop_slot  = vstack_ff[Vw'(vfree_cnt_ff - 1'b1)];
   assign atop_slot  = astack_ff[Aw'(afree_cnt_ff - 1'b1)];

   msq_ram #(.Width(VdW), .Depth(VideoSlots)) u_vdesc (
      .clock(clock), .wr_en(vd_we), .wr_addr(vd_waddr), .wr_data(vd_wdata),
      .rd_addr(vd_raddr), .rd_data(vd_rdata));
   msq_ram #(.Width(AdW), .Depth(AudioSlots)) u_adesc (
      .clock(clock), .wr_en(ad_we), .wr_addr(ad_waddr), .wr_data(ad_wdata),
      .rd_addr(ad_raddr), .rd_data(ad_rdata));

   // read address: tail for a video push, head for a pull
   assign vd_raddr = (cur_ff.cmd == msq_pkg::CMD_PUSH) ? vtail_slot : vhead_slot;
   assign ad_raddr = ahead_slot;
   assign work_pop = (state_ff == S_IDLE) && work_valid;

   // descriptor write on an accepted push
   logic push_ok_v, push_ok_a;
   always_comb begin
      push_ok_v = 1'b0;
      push_ok_a = 1'b0;
      if (state_ff == S_EXEC && cur_ff.cmd == msq_pkg::CMD_PUSH && !cur_ff.too_long) begin
         if (cur_ff.is_audio) begin
            push_ok_a = (afree_cnt_ff != '0);
         end else begin
            push_ok_v = (vfree_cnt_ff != '0) &&
                        (vfifo_cnt_ff == '0 || cur_ff.key || vd_rdata[32:1] + 32'd1 == cur_ff.seq);
         end
      end
   end
   assign vd_we    = push_ok_v;
   assign vd_waddr = vtop_slot;
   assign vd_wdata = {cur_ff.timestamp, cur_ff.length, cur_ff.seq, cur_ff.key};
   assign ad_we    = push_ok_a;
   assign ad_waddr = atop_slot;
   assign ad_wdata = {cur_ff.timestamp, cur_ff.length};

   // build the result of the transaction in execution, zero otherwise
   always_comb begin
      rsp_in = '0;
      if (state_ff == S_EXEC) begin
         case (cur_ff.cmd)
            msq_pkg::CMD_PUSH: begin
               if (cur_ff.too_long) begin
                  rsp_in.status = msq_pkg::ST_TOOLONG;
               end else if (cur_ff.is_audio) begin
                  if (afree_cnt_ff == '0) begin
                     rsp_in.status = msq_pkg::ST_NOSLOT;
                  end else begin
                     rsp_in.slot = 4'(atop_slot);
                  end
               end else if (vfree_cnt_ff == '0) begin
                  rsp_in.status = msq_pkg::ST_NOSLOT;
               end else if (!push_ok_v) begin
                  rsp_in.status = msq_pkg::ST_DROP;
               end else begin
                  rsp_in.slot = 4'(vtop_slot);
               end
            end
            msq_pkg::CMD_PULL: begin
               if (cur_ff.is_audio) begin
                  if (afifo_cnt_ff == '0) begin
                     rsp_in.status = msq_pkg::ST_EMPTY;
                  end else begin
                     rsp_in.slot          = 4'(ahead_slot);
                     rsp_in.out_kind      = msq_pkg::KIND_AUDIO;
                     rsp_in.out_timestamp = ad_rdata[47:16];
                     rsp_in.out_length    = ad_rdata[15:0];
                  end
               end else begin
                  if (vfifo_cnt_ff == '0) begin
                     rsp_in.status = msq_pkg::ST_EMPTY;
                  end else begin
                     rsp_in.slot          = 4'(vhead_slot);
                     rsp_in.out_kind      = {1'b0, vd_rdata[0]};
                     rsp_in.out_timestamp = vd_rdata[80:49];
                     rsp_in.out_length    = vd_rdata[48:33];
                     rsp_in.out_seq       = vd_rdata[32:1];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequence the transaction, hold the result one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid    <= 1'b0;
         vfree_cnt_ff <= (Vw+1)'(VideoSlots);
         afree_cnt_ff <= (Aw+1)'(AudioSlots);
         vfifo_cnt_ff <= '0;
         afifo_cnt_ff <= '0;
         vhead_ff     <= '0;
         ahead_ff     <= '0;
         for (int i = 0; i < VideoSlots; i++) vstack_ff[i] <= Vw'(i);
         for (int i = 0; i < AudioSlots; i++) astack_ff[i] <= Aw'(i);
      end else begin
         rsp_valid <= 1'b0;
         rsp_data  <= rsp_in;
         case (state_ff)
            S_IDLE: begin
               if (work_valid) begin
                  cur_ff   <= work;
                  state_ff <= (work.cmd == msq_pkg::CMD_RESET) ? S_DRAIN_V : S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff  <= S_IDLE;
               rsp_valid <= 1'b1;
               case (cur_ff.cmd)
                  msq_pkg::CMD_PUSH: begin
                     if (push_ok_a) begin
                        afree_cnt_ff <= afree_cnt_ff - 1'b1;
                        afifo_ff[awrap((Aw+1)'(ahead_ff) + afifo_cnt_ff)] <= atop_slot;
                        afifo_cnt_ff <= afifo_cnt_ff + 1'b1;
                     end else if (push_ok_v) begin
                        vfree_cnt_ff <= vfree_cnt_ff - 1'b1;
                        vfifo_ff[vwrap((Vw+1)'(vhead_ff) + vfifo_cnt_ff)] <= vtop_slot;
                        vfifo_cnt_ff <= vfifo_cnt_ff + 1'b1;
                     end
                  end
                  msq_pkg::CMD_PULL: begin
                     if (cur_ff.is_audio) begin
                        if (afifo_cnt_ff != '0) begin
                           ahead_ff     <= awrap((Aw+1)'(ahead_ff) + 1'b1);
                           afifo_cnt_ff <= afifo_cnt_ff - 1'b1;
                           if (afree_cnt_ff < (Aw+1)'(AudioSlots)) begin
                              astack_ff[Aw'(afree_cnt_ff)] <= ahead_slot;
                              afree_cnt_ff <= afree_cnt_ff + 1'b1;
                           end
                        end
                     end else begin
                        if (vfifo_cnt_ff != '0) begin
                           vhead_ff     <= vwrap((Vw+1)'(vhead_ff) + 1'b1);
                           vfifo_cnt_ff <= vfifo_cnt_ff - 1'b1;
                           if (vfree_cnt_ff < (Vw+1)'(VideoSlots)) begin
                              vstack_ff[Vw'(vfree_cnt_ff)] <= vhead_slot;
                              vfree_cnt_ff <= vfree_cnt_ff + 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            S_DRAIN_V: begin
               // return one video slot per cycle
               if (vfifo_cnt_ff != '0 && vfree_cnt_ff < (Vw+1)'(VideoSlots)) begin
                  vstack_ff[Vw'(vfree_cnt_ff)] <= vhead_slot;
                  vfree_cnt_ff <= vfree_cnt_ff + 1'b1;
                  vhead_ff     <= vwrap((Vw+1)'(vhead_ff) + 1'b1);
                  vfifo_cnt_ff <= vfifo_cnt_ff - 1'b1;
               end else begin
                  vfifo_cnt_ff <= '0;
                  state_ff     <= S_DRAIN_A;
               end
            end
            S_DRAIN_A: begin
               if (afifo_cnt_ff != '0 && afree_cnt_ff < (Aw+1)'(AudioSlots)) begin
                  astack_ff[Aw'(afree_cnt_ff)] <= ahead_slot;
                  afree_cnt_ff <= afree_cnt_ff + 1'b1;
                  ahead_ff     <= awrap((Aw+1)'(ahead_ff) + 1'b1);
                  afifo_cnt_ff <= afifo_cnt_ff - 1'b1;
               end else begin
                  afifo_cnt_ff <= '0;
                  state_ff     <= S_IDLE;
                  rsp_valid    <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_vcount: assert property (@(posedge clock) disable iff (reset)
      vfree_cnt_ff + vfifo_cnt_ff <= (Vw+2)'(VideoSlots))
      else $error("video slots exceed pool");
   a_acount: assert property (@(posedge clock) disable iff (reset)
      afree_cnt_ff + afifo_cnt_ff <= (Aw+2)'(AudioSlots))
      else $error("audio slots exceed pool");
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_EXEC || $past(state_ff) == S_DRAIN_A)
      else $error("result without transaction");
endmodule
`default_nettype wire

/* src/media_slot_queue_with_frame_drop_top.sv */
// Order: with the back end idle, an accepted push, pull or idle command is taken from the
// queue, its descriptor RAM is read (S_READ), then written and the result built (S_EXEC) and
// registered; reset queues returns queued video, then audio, slots before its result is strobed.
// The back end takes one transaction at a time; a 2-entry queue between front and back absorbs bursts.
// Reset (synchronous): free stacks full, queues empty, counter 0, limits default.
// Results cannot be stalled; each shows for one cycle under rsp_valid.
`default_nettype none
module media_slot_queue_with_frame_drop_top #(
   parameter int VideoSlots = msq_pkg::VideoSlotsDefault,
   parameter int AudioSlots = msq_pkg::AudioSlotsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire msq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output msq_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [msq_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [msq_pkg::CsrDataWidth-1:0]  csr_wdata
);
   logic              accept, q_empty, q_full, pop;
   msq_pkg::work_type work, head;

   assign busy   = q_full;
   assign accept = start && !busy;

   msq_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .req(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata), .work(work));

   msq_queue u_queue (
      .clock(clock), .reset(reset), .push(accept), .push_data(work),
      .pop(pop), .head(head), .empty(q_empty), .full(q_full));

   msq_back #(.VideoSlots(VideoSlots), .AudioSlots(AudioSlots)) u_back (
      .clock(clock), .reset(reset), .work_valid(!q_empty), .work(head),
      .work_pop(pop), .rsp_valid(rsp_valid), .rsp_data(rsp_data));
endmodule
`default_nettype wire
